// ===== sv/gir_pkg.sv =====
// Shared constants, types and helpers of the gray image rotator.
package gir_pkg;

  localparam int MAX_SIDE = 64;
  localparam int SIDE_W   = $clog2(MAX_SIDE);
  localparam int LEN_W    = SIDE_W + 1;
  localparam int ADDR_W   = 2 * SIDE_W;
  localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
  localparam int CFG_W    = 7;
  localparam int IDX_W    = 2;
  localparam int GRAY_W   = 8;
  localparam int RGB_W    = 16;

  localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_MODE   = 2'd2;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_READ = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic load;
    logic calc;
    logic read;
    logic send;
  } cmd_t;

  function automatic logic [LEN_W-1:0] eff_size(input logic [CFG_W-1:0] v);
    logic [LEN_W-1:0] r;
    if (v == '0) begin
      r = LEN_W'(1);
    end else if (int'(v) > MAX_SIDE) begin
      r = LEN_W'(MAX_SIDE);
    end else begin
      r = LEN_W'(v);
    end
    return r;
  endfunction

  function automatic logic [RGB_W-1:0] to_rgb565(input logic [GRAY_W-1:0] g);
    return {g[7:3], g[7:5], g[4:2], g[7:3]};
  endfunction

endpackage

// ===== sv/gir_ctrl.sv =====
// Controller state machine and output valid flag of the gray image rotator.
module gir_ctrl import gir_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  input  logic s_tuser,
  output logic s_tready,
  output logic m_tvalid,
  input  logic m_tready,
  output cmd_t cmd
);

  state_t state, state_next;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.send) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (func_t'(s_tuser) == FUNC_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.calc   = 1'b1;
            state_next = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd.read   = 1'b1;
        state_next = ST_SEND;
      end
      ST_SEND: begin
        if (out_free) begin
          cmd.send   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== sv/gir_datapath.sv =====
// Datapath: config registers, pixel store, readout counters and output register.
module gir_datapath import gir_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic [GRAY_W-1:0] gray_pixel,
  input  cmd_t              cmd,
  output logic [RGB_W-1:0]  rgb565_pixel,
  output logic              last_pixel
);

  logic [CFG_W-1:0]  image_width;
  logic [CFG_W-1:0]  image_height;
  mode_t             rotation_mode;

  logic [GRAY_W-1:0] pixel_store [DEPTH];
  logic [ADDR_W-1:0] load_position;
  logic [SIDE_W-1:0] out_row;
  logic [SIDE_W-1:0] out_column;
  logic [ADDR_W-1:0] rd_addr;
  logic              last_q;
  logic              last_q2;
  logic [GRAY_W-1:0] rd_data;

  logic [LEN_W-1:0]    w_eff, h_eff, outer_len, inner_len;
  logic [2*LEN_W-1:0]  total;
  logic [ADDR_W-1:0]   wr_pos;
  logic [ADDR_W:0]     pos_inc;
  logic [ADDR_W-1:0]   load_position_next;
  logic                restart;
  logic [SIDE_W-1:0]   cur_row, cur_col, pix_r, pix_c;
  logic [SIDE_W-1:0]   out_row_next, out_column_next;
  logic [2*LEN_W-1:0]  lin_addr;
  logic                last_next;

  assign w_eff = eff_size(image_width);
  assign h_eff = eff_size(image_height);
  assign total = w_eff * h_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= CFG_W'(MAX_SIDE);
      image_height  <= CFG_W'(MAX_SIDE);
      rotation_mode <= ROT_0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  image_width   <= cfg_data;
        REG_HEIGHT: image_height  <= cfg_data;
        REG_MODE:   rotation_mode <= mode_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  // load position, wrapped to the current image size
  always_comb begin
    wr_pos = ((2*LEN_W)'(load_position) >= total) ? '0 : load_position;
    pos_inc = {1'b0, wr_pos} + (ADDR_W+1)'(1);
    load_position_next = ((2*LEN_W)'(pos_inc) >= total) ? '0 : pos_inc[ADDR_W-1:0];
  end

  // readout order mapping
  always_comb begin
    if (rotation_mode == ROT_0 || rotation_mode == ROT_180) begin
      outer_len = h_eff;
      inner_len = w_eff;
    end else begin
      outer_len = w_eff;
      inner_len = h_eff;
    end
    restart = (LEN_W'(out_row) >= outer_len) || (LEN_W'(out_column) >= inner_len);
    cur_row = restart ? '0 : out_row;
    cur_col = restart ? '0 : out_column;
    case (rotation_mode)
      ROT_0: begin
        pix_r = cur_row;
        pix_c = cur_col;
      end
      ROT_90: begin
        pix_c = cur_row;
        pix_r = SIDE_W'(h_eff - LEN_W'(1) - LEN_W'(cur_col));
      end
      ROT_180: begin
        pix_r = SIDE_W'(h_eff - LEN_W'(1) - LEN_W'(cur_row));
        pix_c = SIDE_W'(w_eff - LEN_W'(1) - LEN_W'(cur_col));
      end
      default: begin
        pix_c = SIDE_W'(w_eff - LEN_W'(1) - LEN_W'(cur_row));
        pix_r = cur_col;
      end
    endcase
    lin_addr  = LEN_W'(pix_r) * w_eff + (2*LEN_W)'(pix_c);
    last_next = (LEN_W'(cur_row) == outer_len - LEN_W'(1))
             && (LEN_W'(cur_col) == inner_len - LEN_W'(1));
    if (LEN_W'(cur_col) + LEN_W'(1) >= inner_len) begin
      out_column_next = '0;
      out_row_next    = (LEN_W'(cur_row) + LEN_W'(1) >= outer_len) ? '0
                        : cur_row + SIDE_W'(1);
    end else begin
      out_column_next = cur_col + SIDE_W'(1);
      out_row_next    = cur_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_position <= '0;
      out_row       <= '0;
      out_column    <= '0;
    end else if (cmd.load) begin
      load_position <= load_position_next;
      out_row       <= '0;
      out_column    <= '0;
    end else if (cmd.calc) begin
      out_row       <= out_row_next;
      out_column    <= out_column_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pixel_store[wr_pos] <= gray_pixel;
    end
    if (cmd.read) begin
      rd_data <= pixel_store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      rd_addr <= lin_addr[ADDR_W-1:0];
      last_q  <= last_next;
    end
    if (cmd.read) begin
      last_q2 <= last_q;
    end
    if (cmd.send) begin
      rgb565_pixel <= to_rgb565(rd_data);
      last_pixel   <= last_q2;
    end
  end

endmodule

// ===== sv/gray_image_rotate_to_rgb565_unit.sv =====
// Top level of the gray image rotator with RGB565 output.
//
//   channel  direction  payload
//   s_*      in         tuser: func; tdata: gray_pixel
//   m_*      out        tdata: rgb565_pixel; tlast: last_pixel
//   cfg_*    in         cfg_index selects width, height or mode; cfg_data value
//
// A load transfer is one store write. A read request passes through the address
// multiply, the registered store read, then the output register load.
// While a result waits in the output register, loads and one more request are
// accepted; that request then holds in its last state and blocks s until m_tready.
// rst is synchronous and clears control state and config; the store is not cleared.
module gray_image_rotate_to_rgb565_unit import gir_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [GRAY_W-1:0] s_tdata,   // [7:0] gray_pixel
  input  logic              s_tuser,   // [0] func
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [RGB_W-1:0]  m_tdata,   // [15:0] rgb565_pixel
  output logic              m_tlast
);

  cmd_t cmd;

  gir_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  gir_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .gray_pixel   (s_tdata),
    .cmd          (cmd),
    .rgb565_pixel (m_tdata),
    .last_pixel   (m_tlast)
  );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for gray_image_rotate_to_rgb565_unit: random loads, readouts and stalls.
`timescale 1ns / 1ps

module testbench;
  import gir_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 2000;
  localparam int MAX_FRAME      = 256;

  class rotator_scoreboard;
    typedef struct packed {
      logic [RGB_W-1:0] pixel;
      logic             last;
    } rgb_result_t;

    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    mode_t             mode;
    logic [GRAY_W-1:0] store [DEPTH];
    int unsigned       load_pos;
    int unsigned       out_row;
    int unsigned       out_col;
    int unsigned       filled;
    int                errors;
    rgb_result_t       expected_pixels[$];

    function new();
      width_reg  = CFG_W'(MAX_SIDE);
      height_reg = CFG_W'(MAX_SIDE);
      mode       = ROT_0;
      load_pos   = 0;
      out_row    = 0;
      out_col    = 0;
      filled     = 0;
      errors     = 0;
    endfunction

    function int unsigned side_len(logic [CFG_W-1:0] v);
      if (v == 0) return 1;
      if (int'(v) > MAX_SIDE) return MAX_SIDE;
      return int'(v);
    endfunction

    function int unsigned frame_size();
      return side_len(width_reg) * side_len(height_reg);
    endfunction

    // every entry the readout can touch has been loaded
    function bit readable();
      return frame_size() <= filled;
    endfunction

    function logic [RGB_W-1:0] gray_to_rgb565(logic [GRAY_W-1:0] g);
      logic [15:0] gw;
      logic [15:0] hi;
      logic [15:0] lo;
      gw = {8'h00, g};
      hi = (gw & 16'h00F8) | (gw >> 5);
      lo = ((gw << 3) & 16'h00E0) | (gw >> 3);
      return {hi[7:0], lo[7:0]};
    endfunction

    function void set_register(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_WIDTH:  width_reg = val;
        REG_HEIGHT: height_reg = val;
        REG_MODE:   mode = mode_t'(val[1:0]);
        default: ;
      endcase
    endfunction

    function void note_pixel_in(func_t f, logic [GRAY_W-1:0] g);
      int unsigned w;
      int unsigned h;
      int unsigned total;
      int unsigned pos;
      int unsigned outer_len;
      int unsigned inner_len;
      int unsigned r;
      int unsigned c;
      rgb_result_t e;
      w = side_len(width_reg);
      h = side_len(height_reg);
      total = w * h;
      if (f == FUNC_LOAD) begin
        pos = load_pos;
        if (pos >= total) pos = 0;
        store[pos] = g;
        if (pos + 1 > filled) filled = pos + 1;
        pos++;
        if (pos >= total) pos = 0;
        load_pos = pos;
        out_row = 0;
        out_col = 0;
        return;
      end
      if (mode == ROT_0 || mode == ROT_180) begin
        outer_len = h;
        inner_len = w;
      end else begin
        outer_len = w;
        inner_len = h;
      end
      if (out_row >= outer_len || out_col >= inner_len) begin
        out_row = 0;
        out_col = 0;
      end
      case (mode)
        ROT_0: begin
          r = out_row;
          c = out_col;
        end
        ROT_90: begin
          c = out_row;
          r = h - 1 - out_col;
        end
        ROT_180: begin
          r = h - 1 - out_row;
          c = w - 1 - out_col;
        end
        default: begin
          c = w - 1 - out_row;
          r = out_col;
        end
      endcase
      e.pixel = gray_to_rgb565(store[(r * w + c) % DEPTH]);
      e.last  = (out_row == outer_len - 1) && (out_col == inner_len - 1);
      if (out_col + 1 >= inner_len) begin
        out_col = 0;
        if (out_row + 1 >= outer_len) out_row = 0;
        else out_row++;
      end else begin
        out_col++;
      end
      expected_pixels.push_back(e);
    endfunction

    function void check_pixel_out(logic [RGB_W-1:0] pix, logic lst);
      rgb_result_t e;
      if (expected_pixels.size() == 0) begin
        $error("rgb565_pixel: expected none, actual %h", pix);
        errors++;
        return;
      end
      e = expected_pixels.pop_front();
      if (pix !== e.pixel) begin
        $error("rgb565_pixel: expected %h, actual %h", e.pixel, pix);
        errors++;
      end
      if (lst !== e.last) begin
        $error("last_pixel: expected %b, actual %b", e.last, lst);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_we;
  logic [IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]  cfg_data;
  logic              s_tvalid;
  logic              s_tready;
  logic [GRAY_W-1:0] s_tdata;
  logic              s_tuser;
  logic              m_tvalid;
  logic              m_tready;
  logic [RGB_W-1:0]  m_tdata;
  logic              m_tlast;

  rotator_scoreboard sb;
  bit steady_flow;
  int items_sent;
  int quiet_cycles;
  int ready_hold;
  int ready_roll;

  gray_image_rotate_to_rgb565_unit dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_pixel_in(func_t'(s_tuser), s_tdata);
      if (m_tvalid && m_tready) sb.check_pixel_out(m_tdata, m_tlast);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (ready_hold > 0) begin
      m_tready <= 1'b0;
      ready_hold--;
    end else if (steady_flow) begin
      m_tready <= 1'b1;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 70) begin
        m_tready <= 1'b1;
      end else if (ready_roll < 95) begin
        m_tready <= 1'b0;
        ready_hold = $urandom_range(0, 2);
      end else begin
        m_tready <= 1'b0;
        ready_hold = $urandom_range(10, 40);
      end
    end
  end

  function automatic int gap_cycles();
    int roll;
    if (steady_flow) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [CFG_W-1:0] pick_side();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return CFG_W'($urandom_range(1, 8));
    if (roll < 72) return CFG_W'($urandom_range(9, 24));
    if (roll < 80) return CFG_W'(MAX_SIDE);
    if (roll < 88) return '0;
    if (roll < 95) return CFG_W'($urandom_range(MAX_SIDE + 1, 127));
    return CFG_W'($urandom_range(25, MAX_SIDE - 1));
  endfunction

  // tasks start and end at a falling edge
  task automatic send_pixel(func_t f, logic [GRAY_W-1:0] g);
    int gap;
    gap = gap_cycles();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= f;
    s_tdata  <= g;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic load_pixels(int n);
    repeat (n) send_pixel(FUNC_LOAD, GRAY_W'($urandom_range(0, 255)));
  endtask

  task automatic request_pixels(int n);
    repeat (n) send_pixel(FUNC_READ, GRAY_W'($urandom_range(0, 255)));
  endtask

  task automatic mixed_items(int n, int read_pct);
    repeat (n) begin
      if (sb.readable() && $urandom_range(0, 99) < read_pct) request_pixels(1);
      else load_pixels(1);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_register(idx, val);
    @(negedge clk);
  endtask

  task automatic write_size();
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] h;
    w = pick_side();
    h = pick_side();
    if (sb.side_len(w) * sb.side_len(h) > MAX_FRAME) begin
      if ($urandom_range(0, 1) == 0) w = CFG_W'($urandom_range(0, 4));
      else h = CFG_W'($urandom_range(0, 4));
    end
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  task automatic run_directed();
    // zero sizes act as a 1x1 image; second read wraps
    write_reg(REG_WIDTH, '0);
    write_reg(REG_HEIGHT, '0);
    write_reg(REG_MODE, CFG_W'(ROT_0));
    send_pixel(FUNC_LOAD, 8'h00);
    request_pixels(1);
    send_pixel(FUNC_LOAD, 8'hFF);
    request_pixels(2);
    drain();
    write_reg(REG_WIDTH, 7'd2);
    write_reg(REG_HEIGHT, 7'd2);
    write_reg(REG_MODE, CFG_W'(ROT_90));
    send_pixel(FUNC_LOAD, 8'hA5);
    send_pixel(FUNC_LOAD, 8'h5A);
    send_pixel(FUNC_LOAD, 8'h0F);
    send_pixel(FUNC_LOAD, 8'hF0);
    request_pixels(2);
    // mode change mid-readout keeps the counters
    drain();
    write_reg(REG_MODE, CFG_W'(ROT_270));
    request_pixels(2);
    drain();
    write_reg(REG_MODE, CFG_W'(ROT_180));
    request_pixels(4);
    load_pixels(3);
    drain();
    write_reg(REG_MODE, CFG_W'(ROT_0));
    request_pixels(3);
    // shrink: counters out of range, load position past the frame
    drain();
    write_reg(REG_WIDTH, 7'd1);
    request_pixels(1);
    load_pixels(1);
    request_pixels(1);
  endtask

  task automatic run_random();
    int kind;
    int n;
    while (items_sent < RANDOM_ITEMS) begin
      drain();
      steady_flow = ($urandom_range(0, 4) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        write_size();
        write_reg(REG_MODE, CFG_W'($urandom_range(0, 3)));
        n = sb.frame_size();
        load_pixels(n);
        request_pixels(n + $urandom_range(0, n));
      end else if (kind < 75) begin
        write_reg(REG_MODE, CFG_W'($urandom_range(0, 3)));
        mixed_items($urandom_range(1, 30), 100);
      end else if (kind < 88) begin
        mixed_items($urandom_range(10, 40), 50);
      end else begin
        write_size();
        mixed_items($urandom_range(10, 40), 70);
      end
    end
  endtask

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = 1'b0;
    m_tready     = 1'b0;
    steady_flow  = 1'b0;
    items_sent   = 0;
    quiet_cycles = 0;
    ready_hold   = 0;
    sb = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    run_directed();
    run_random();
    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.expected_pixels.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
